// File: design/ccl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared types, constants and tables for the CORDIC circular/linear unit.
// ----------------------------------------------------------------------------
package ccl_pkg;

	localparam int WORD_BITS  = 32;
	localparam int FRAC_BITS  = 16;
	localparam int MAX_ITER   = 31;
	localparam int ITER_BITS  = 5;
	localparam int KIND_BITS  = 3;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [KIND_BITS-1:0]        kind_t;
	typedef logic [ITER_BITS-1:0]        iter_t;

	// Item kinds
	localparam kind_t KIND_CIRC_ROT = 3'd0;
	localparam kind_t KIND_CIRC_VEC = 3'd1;
	localparam kind_t KIND_LIN_ROT  = 3'd2;
	localparam kind_t KIND_LIN_VEC  = 3'd3;
	localparam kind_t KIND_COS_SIN  = 3'd4;
	localparam kind_t KIND_MAG      = 3'd5;

	// Register indexes
	localparam logic [0:0] REG_ITER_COUNT = 1'b0;
	localparam iter_t      ITER_RESET     = 5'd16;

	// Constants rounded half up at 16 fraction bits
	localparam word_t INV_K   = 32'sd39797;
	localparam word_t PI_FIX  = 32'sd205887;
	localparam word_t HPI_FIX = 32'sd102944;

	// atan(2^-i), rounded at 16 fraction bits
	function automatic word_t atan_tab(input iter_t i);
		word_t r;
		unique case (i)
			5'd0:  r = 32'sd51472;
			5'd1:  r = 32'sd30386;
			5'd2:  r = 32'sd16055;
			5'd3:  r = 32'sd8150;
			5'd4:  r = 32'sd4091;
			5'd5:  r = 32'sd2047;
			5'd6:  r = 32'sd1024;
			5'd7:  r = 32'sd512;
			5'd8:  r = 32'sd256;
			5'd9:  r = 32'sd128;
			5'd10: r = 32'sd64;
			5'd11: r = 32'sd32;
			5'd12: r = 32'sd16;
			5'd13: r = 32'sd8;
			5'd14: r = 32'sd4;
			5'd15: r = 32'sd2;
			5'd16: r = 32'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Linear step 2^-i, truncated (zero past the fraction)
	function automatic word_t lin_tab(input iter_t i);
		word_t r;
		if (int'(i) > FRAC_BITS) r = '0;
		else r = word_t'(64'sd1 <<< (FRAC_BITS - int'(i)));
		return r;
	endfunction

	// Stage payload
	typedef struct packed {
		kind_t kind;
		logic  linear;
		logic  vec;
		logic  neg_x;
		logic  neg_y;
		word_t x;
		word_t y;
		word_t z;
	} stage_t;

endpackage

// File: design/ccl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccl_if
// Valid/ready channel carrying one x, y, z item and its kind.
// ----------------------------------------------------------------------------
interface ccl_if;
	logic            valid;
	logic            ready;
	ccl_pkg::kind_t  kind;
	ccl_pkg::word_t  x_in;
	ccl_pkg::word_t  y_in;
	ccl_pkg::word_t  z_in;
	ccl_pkg::word_t  x_out;
	ccl_pkg::word_t  y_out;
	ccl_pkg::word_t  z_out;

	modport source (output valid, kind, x_in, y_in, z_in, x_out, y_out, z_out,
		input ready);
	modport sink (input valid, kind, x_in, y_in, z_in, x_out, y_out, z_out,
		output ready);
endinterface

// File: design/cordic_circular_linear_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_circular_linear_unit_core
// Pipelined fixed-point CORDIC: circular/linear rotation and vectoring,
// cosine/sine with angle folding, and magnitude.
// ----------------------------------------------------------------------------
// One item enters per clock unless stalled. Whatever the iteration count,
// each item passes an entry stage (operand preparation), 31 micro-rotation
// stages, two scaling stages (split 16x16 products for the magnitude) and an
// output register. Stages beyond iteration_count pass their item through.
// Each stage holds when its successor is full and stalled, so back-pressure
// loses nothing. iteration_count should change only with the pipe empty.
module cordic_circular_linear_unit_core (
	input  logic   clk,
	input  logic   arst_n,
	ccl_if.sink    in_ch,
	ccl_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int NS = ccl_pkg::MAX_ITER + 4;

	ccl_pkg::iter_t iter_q;
	ccl_pkg::stage_t st_s [NS];
	logic            vl_s [NS];
	logic            adv  [NS];
	ccl_pkg::stage_t nx   [NS];

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ccl_pkg::REG_ITER_COUNT) ? {27'd0, iter_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= ccl_pkg::ITER_RESET;
		end else if (psel && penable && pwrite && paddr[2] == ccl_pkg::REG_ITER_COUNT) begin
			iter_q <= pwdata[4:0];
		end
	end

	// Flow control: a stage loads when it is empty or moving on
	always_comb begin
		adv[NS-1] = !vl_s[NS-1] || out_ch.ready;
		for (int k = NS - 2; k >= 0; k--) begin
			adv[k] = !vl_s[k] || adv[k+1];
		end
	end
	assign in_ch.ready = adv[0];

	// Entry stage: kind decode, angle folding, absolute values
	always_comb begin
		ccl_pkg::word_t th;
		th = in_ch.z_in;
		nx[0] = '0;
		nx[0].kind = in_ch.kind;
		nx[0].x = in_ch.x_in;
		nx[0].y = in_ch.y_in;
		nx[0].z = in_ch.z_in;
		unique case (in_ch.kind)
			ccl_pkg::KIND_CIRC_VEC: nx[0].vec = 1'b1;
			ccl_pkg::KIND_LIN_ROT:  nx[0].linear = 1'b1;
			ccl_pkg::KIND_LIN_VEC: begin
				nx[0].linear = 1'b1;
				nx[0].vec = 1'b1;
			end
			ccl_pkg::KIND_COS_SIN: begin
				nx[0].x = ccl_pkg::INV_K;
				nx[0].y = '0;
				if (th > ccl_pkg::HPI_FIX) begin
					nx[0].z = ccl_pkg::PI_FIX - th;
					nx[0].neg_x = 1'b1;
				end else if (th < -ccl_pkg::HPI_FIX) begin
					nx[0].z = ccl_pkg::PI_FIX + th;
					nx[0].neg_x = 1'b1;
					nx[0].neg_y = 1'b1;
				end
			end
			ccl_pkg::KIND_MAG: begin
				nx[0].vec = 1'b1;
				if (in_ch.x_in <= 0) nx[0].x = -in_ch.x_in;
				if (in_ch.y_in <= 0) nx[0].y = -in_ch.y_in;
				nx[0].z = '0;
			end
			default: ;
		endcase
	end

	// Micro-rotation stages
	for (genvar g = 0; g < ccl_pkg::MAX_ITER; g++) begin : g_rot
		localparam ccl_pkg::iter_t IDX = ccl_pkg::iter_t'(g);
		always_comb begin
			ccl_pkg::stage_t c;
			ccl_pkg::word_t xs, ys, a;
			logic up, act;
			c = st_s[g];
			xs = c.x >>> IDX;
			ys = c.y >>> IDX;
			a = c.linear ? ccl_pkg::lin_tab(IDX) : ccl_pkg::atan_tab(IDX);
			act = (c.kind <= ccl_pkg::KIND_MAG) && (IDX < iter_q);
			if (c.vec) up = !((c.x > 0 && c.y > 0) || (c.x < 0 && c.y < 0));
			else       up = c.z > 0;
			nx[g+1] = c;
			if (act) begin
				if (up) begin
					nx[g+1].x = c.linear ? c.x : c.x - ys;
					nx[g+1].y = c.y + xs;
					nx[g+1].z = c.z - a;
				end else begin
					nx[g+1].x = c.linear ? c.x : c.x + ys;
					nx[g+1].y = c.y - xs;
					nx[g+1].z = c.z + a;
				end
			end
		end
	end

	// Scaling stage A: split product of |x| and 1/K
	localparam int PA = ccl_pkg::MAX_ITER + 1;
	logic [31:0] mag_a;
	logic        mneg_a, mneg_b;
	logic [31:0] ph_b, pl_b;
	always_comb begin
		ccl_pkg::stage_t c;
		c = st_s[PA-1];
		nx[PA] = c;
		mag_a = c.x[31] ? 32'(-c.x) : 32'(c.x);
		mneg_a = c.x[31];
	end

	// Scaling stage B: combine partial products, floor
	always_comb begin
		ccl_pkg::stage_t c;
		logic [47:0] q;
		logic [15:0] rem;
		c = st_s[PA];
		nx[PA+1] = c;
		q = {16'd0, ph_b} + {32'd0, pl_b[31:16]};
		rem = pl_b[15:0];
		if (c.kind == ccl_pkg::KIND_MAG) begin
			if (mneg_b) nx[PA+1].x = ccl_pkg::word_t'(48'd0 - q - {47'd0, rem != 0});
			else        nx[PA+1].x = ccl_pkg::word_t'(q);
		end
	end

	// Output fix-up for cosine/sine quadrants
	always_comb begin
		ccl_pkg::stage_t c;
		c = st_s[PA+1];
		nx[PA+2] = c;
		if (c.kind == ccl_pkg::KIND_COS_SIN) begin
			if (c.neg_x) nx[PA+2].x = -c.x;
			if (c.neg_y) nx[PA+2].y = -c.y;
		end
	end

	// Pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) vl_s[k] <= 1'b0;
		end else begin
			if (adv[0]) vl_s[0] <= in_ch.valid;
			for (int k = 1; k < NS; k++) begin
				if (adv[k]) vl_s[k] <= vl_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) st_s[0] <= nx[0];
		for (int k = 1; k < NS; k++) begin
			if (adv[k]) st_s[k] <= nx[k];
		end
		if (adv[PA]) begin
			ph_b <= {16'd0, mag_a[31:16]} * {16'd0, ccl_pkg::INV_K[15:0]};
			pl_b <= {16'd0, mag_a[15:0]} * {16'd0, ccl_pkg::INV_K[15:0]};
			mneg_b <= mneg_a;
		end
	end

	assign out_ch.valid = vl_s[NS-1];
	assign out_ch.x_out = st_s[NS-1].x;
	assign out_ch.y_out = st_s[NS-1].y;
	assign out_ch.z_out = st_s[NS-1].z;
	assign out_ch.kind  = st_s[NS-1].kind;
	assign out_ch.x_in  = '0;
	assign out_ch.y_in  = '0;
	assign out_ch.z_in  = '0;

endmodule

// File: test/cordic_circular_linear_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_circular_linear_unit_checker
// Watches both item channels and predicts each result from the accepted input
// item. Results are compared field by field, oldest expectation first.
// ----------------------------------------------------------------------------
module cordic_circular_linear_unit_checker (
	input  logic          clk,
	input  logic          arst_n,
	ccl_if                in_ch,
	ccl_if                out_ch,
	input  ccl_pkg::iter_t iter_count,
	output int            fail_count,
	output int            pending
);
	import ccl_pkg::*;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
	} xyz_t;

	xyz_t awaited_q[$];

	// Table of atan(2^-i) at 16 fraction bits; zero past index 16
	function automatic word_t angle_of(int i);
		word_t t [0:16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1};
		return (i <= 16) ? t[i] : word_t'(0);
	endfunction

	// Micro-rotations on x, y, z
	function automatic void rotate(ref word_t x, ref word_t y, ref word_t z,
			input bit lin, input bit vec, input iter_t n_cfg);
		int    n;
		word_t cx, cy, xs, ys, a;
		bit    up;
		n = (n_cfg > MAX_ITER) ? MAX_ITER : int'(n_cfg);
		for (int i = 0; i < n; i++) begin
			cx = x;
			cy = y;
			xs = cx >>> i;
			ys = cy >>> i;
			a  = lin ? ((i > FRAC_BITS) ? word_t'(0) : word_t'(1 << (FRAC_BITS - i)))
				: angle_of(i);
			if (vec)
				up = !((cx > 0 && cy > 0) || (cx < 0 && cy < 0));
			else
				up = (z > 0);
			if (up) begin
				if (!lin) x = cx - ys;
				y = cy + xs;
				z = z - a;
			end else begin
				if (!lin) x = cx + ys;
				y = cy - xs;
				z = z + a;
			end
		end
	endfunction

	function automatic xyz_t cordic_result(kind_t k, word_t xi, word_t yi, word_t zi,
			iter_t n);
		word_t x, y, z;
		logic signed [63:0] p;
		x = xi;
		y = yi;
		z = zi;
		case (k)
			KIND_CIRC_ROT: rotate(x, y, z, 0, 0, n);
			KIND_CIRC_VEC: rotate(x, y, z, 0, 1, n);
			KIND_LIN_ROT:  rotate(x, y, z, 1, 0, n);
			KIND_LIN_VEC:  rotate(x, y, z, 1, 1, n);
			KIND_COS_SIN: begin
				// fold the angle into [-pi/2, pi/2]
				if (zi > HPI_FIX)       z = PI_FIX - zi;
				else if (zi < -HPI_FIX) z = PI_FIX + zi;
				x = INV_K;
				y = 0;
				rotate(x, y, z, 0, 0, n);
				if (zi > HPI_FIX || zi < -HPI_FIX) x = -x;
				if (zi < -HPI_FIX) y = -y;
			end
			KIND_MAG: begin
				if (!(x > 0)) x = -x;
				if (!(y > 0)) y = -y;
				z = 0;
				rotate(x, y, z, 0, 1, n);
				p = (64'(x) * 64'(INV_K)) >>> FRAC_BITS;
				x = p[31:0];
			end
			default: ;
		endcase
		return '{x: x, y: y, z: z};
	endfunction

	task automatic report_mismatch(string field, word_t got, word_t want);
		$display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
		fail_count++;
	endtask

	assign pending = awaited_q.size();

	initial fail_count = 0;

	// Capture inputs and check outputs at each rising edge
	always @(posedge clk) begin
		xyz_t w;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				awaited_q.push_back(cordic_result(in_ch.kind, in_ch.x_in, in_ch.y_in,
					in_ch.z_in, iter_count));
			if (out_ch.valid && out_ch.ready) begin
				if (awaited_q.size() == 0) begin
					$display("unexpected result item at %0t", $realtime);
					fail_count++;
				end else begin
					w = awaited_q.pop_front();
					if (out_ch.x_out !== w.x) report_mismatch("x_out", out_ch.x_out, w.x);
					if (out_ch.y_out !== w.y) report_mismatch("y_out", out_ch.y_out, w.y);
					if (out_ch.z_out !== w.z) report_mismatch("z_out", out_ch.z_out, w.z);
				end
			end
		end
	end
endmodule

// File: test/cordic_circular_linear_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_circular_linear_unit_core_tb
// Drives directed and random items through the CORDIC unit over several
// iteration counts, with random gaps on both channels; a checker compares.
// ----------------------------------------------------------------------------
module cordic_circular_linear_unit_core_tb;
	import ccl_pkg::*;

	localparam int LATENCY = 35;
	localparam int CYCLE_LIMIT = 2000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic        pready;
	iter_t       iter_count = ITER_RESET;
	int          fail_count, pending;
	int          cycles = 0;

	ccl_if in_ch();
	ccl_if out_ch();

	initial begin
		in_ch.valid = 0;
		in_ch.kind = '0;
		in_ch.x_in = '0;
		in_ch.y_in = '0;
		in_ch.z_in = '0;
		out_ch.ready = 0;
	end

	cordic_circular_linear_unit_core u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	cordic_circular_linear_unit_checker u_chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.iter_count(iter_count), .fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Result side: random stalls per item, with quiet stretches
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
			repeat (gap) @(negedge clk);
			out_ch.ready <= 1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
			@(negedge clk);
			out_ch.ready <= 0;
		end
	end

	task automatic write_iter(iter_t v);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= 3'(4 * REG_ITER_COUNT);
		pwdata <= 32'(v);
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		iter_count = v;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic send_item(kind_t k, word_t x, word_t y, word_t z, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 16);
		repeat (gap) @(negedge clk);
		in_ch.kind <= k;
		in_ch.x_in <= x;
		in_ch.y_in <= y;
		in_ch.z_in <= z;
		in_ch.valid <= 1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		in_ch.valid <= 0;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic word_t rand_word();
		case ($urandom_range(0, 5))
			0: return word_t'($urandom());
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			default: return word_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
		endcase
	endfunction

	initial begin
		iter_t settings [6] = '{5'd1, 5'd31, 5'd0, 5'd8, 5'd20, 5'd16};
		bit burst;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: every kind, field extremes, angle folding and zeros
		for (int k = 0; k < 8; k++) begin
			send_item(kind_t'(k), 32'sh7fffffff, 32'sh80000000, 0, 0);
			send_item(kind_t'(k), 0, 0, 32'sh80000000, 1);
			send_item(kind_t'(k), 65536, -65536, 32'sh7fffffff, 0);
		end
		send_item(KIND_COS_SIN, 0, 0, HPI_FIX, 0);
		send_item(KIND_COS_SIN, 0, 0, -HPI_FIX, 0);
		send_item(KIND_COS_SIN, 0, 0, 150000, 1);
		drain();

		// Random items across several iteration counts
		foreach (settings[s]) begin
			write_iter(settings[s]);
			for (int n = 0; n < 117; n++) begin
				burst = ($urandom_range(0, 3) == 0);
				send_item(kind_t'($urandom_range(0, 7)), rand_word(), rand_word(),
					($urandom_range(0, 1) != 0) ? rand_word()
						: word_t'($signed($urandom_range(0, 411774)) - 205887), burst);
			end
			drain();
		end

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
